// ===== hdl/pchg_pkg.sv =====
// ---------------------------------------------------------------------------
// pchg_pkg
// Shared types and constants of the point cloud height grid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pchg_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_CROP_Z_MIN    = 3'd0;
    localparam logic [2:0] REG_CROP_Z_MAX    = 3'd1;
    localparam logic [2:0] REG_OVERHEAD      = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE     = 3'd3;
    localparam logic [2:0] REG_ROI_CENTER_X  = 3'd4;

    localparam int CoordW = 24;
    localparam int CsW    = 16;
    localparam int CntW   = 16;

    // One grid cell as stored in memory
    typedef struct packed {
        logic                     used;
        logic [CntW-1:0]          count;
        logic signed [CoordW-1:0] hmax;
        logic signed [CoordW-1:0] hmin;
        logic                     low_used;
        logic signed [CoordW-1:0] low_max;
    } t_cell;

endpackage

`default_nettype wire

// ===== hdl/pchg_div.sv =====
// ---------------------------------------------------------------------------
// pchg_div
// Restoring divider, one quotient bit per cycle, two dividends in parallel
// sharing one divisor. Dividends are nonnegative and below divisor << QB.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pchg_div
    import pchg_pkg::*;
#(
    parameter int DW = 30,
    parameter int QB = 6
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire [DW-1:0]   i_num_a,
    input  wire [DW-1:0]   i_num_b,
    input  wire [CsW:0]    i_den,
    output logic           o_done,
    output logic [QB-1:0]  o_quo_a,
    output logic [QB-1:0]  o_quo_b
);

    localparam int CW = $clog2(QB + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_ra;
    logic [DW-1:0]   r_rb;
    logic [DW-1:0]   r_dv;
    logic [QB-1:0]   r_qa;
    logic [QB-1:0]   r_qb;
    logic            ge_a;
    logic            ge_b;

    assign ge_a = (r_ra >= r_dv);
    assign ge_b = (r_rb >= r_dv);

    // Control: count quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: trial subtract and shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ra <= i_num_a;
            r_rb <= i_num_b;
            r_dv <= DW'(i_den) << (QB - 1);
            r_qa <= '0;
            r_qb <= '0;
        end else if (r_busy) begin
            if (ge_a) begin
                r_ra <= r_ra - r_dv;
            end
            if (ge_b) begin
                r_rb <= r_rb - r_dv;
            end
            r_qa <= QB'({r_qa, ge_a});
            r_qb <= QB'({r_qb, ge_b});
            r_dv <= r_dv >> 1;
        end
    end

    assign o_done  = r_done;
    assign o_quo_a = r_qa;
    assign o_quo_b = r_qb;

endmodule

`default_nettype wire

// ===== hdl/point_cloud_height_grid.sv =====
// ---------------------------------------------------------------------------
// point_cloud_height_grid
// Bins millimetre lidar points into a GRID_X by GRID_Y cell grid and keeps
// per-cell count, max, min and low-layer max heights in one cell memory.
// ---------------------------------------------------------------------------
// Words are handled one at a time. A point passes through the shared
// bit-serial divider, which forms row and column as QB quotient bits (QB
// is the bit count of the larger grid side), then one memory read and one
// write back. A dropped point is discarded in the idle state. A cell read
// passes through a memory read, then waits for the result register to drain.
// A clear sweeps all GRID_X * GRID_Y memory entries, one entry per cycle;
// it runs after reset too. Words stall during it; configuration writes do not.
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_height_grid
    import pchg_pkg::*;
#(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wen,
    input  wire  [2:0]               i_cfg_idx,
    input  wire  [CoordW-1:0]        i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  [1:0]               i_op,
    input  wire  signed [CoordW-1:0] i_point_x,
    input  wire  signed [CoordW-1:0] i_point_y,
    input  wire  signed [CoordW-1:0] i_point_z,
    input  wire                      i_point_finite,
    input  wire  [5:0]               i_read_row,
    input  wire  [5:0]               i_read_col,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic                     o_cell_occupied,
    output logic [CntW-1:0]          o_hit_count,
    output logic signed [CoordW-1:0] o_z_top,
    output logic signed [CoordW-1:0] o_z_bottom,
    output logic                     o_low_occupied,
    output logic signed [CoordW-1:0] o_low_z_top
);

    localparam int NC   = GRID_X * GRID_Y;
    localparam int AW   = $clog2(NC);
    localparam int XW   = $clog2(GRID_X);
    localparam int YW   = $clog2(GRID_Y);
    localparam int QB   = (XW > YW) ? XW : YW;
    localparam int GMAX = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GW   = $clog2(GMAX + 1);
    localparam int OXW  = ((CoordW + 2 > CsW + GW) ? CoordW + 2 : CsW + GW) + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RDP  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_RESP = 3'd5;

    // Configuration registers
    logic signed [CoordW-1:0] r_zmin;
    logic signed [CoordW-1:0] r_zmax;
    logic signed [CoordW-1:0] r_split;
    logic [CsW-1:0]           r_cs;
    logic signed [CoordW-1:0] r_rcx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zmin  <= -CoordW'(2000);
            r_zmax  <= CoordW'(3000);
            r_split <= CoordW'(2000);
            r_cs    <= CsW'(100);
            r_rcx   <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_CROP_Z_MIN:   r_zmin  <= i_cfg_data;
                REG_CROP_Z_MAX:   r_zmax  <= i_cfg_data;
                REG_OVERHEAD:     r_split <= i_cfg_data;
                REG_CELL_SIZE:    r_cs    <= i_cfg_data[CsW-1:0];
                REG_ROI_CENTER_X: r_rcx   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control registers
    logic [2:0]               r_st;
    logic [AW-1:0]            r_addr;
    logic                     r_isread;
    logic                     r_rzero;
    logic signed [CoordW-1:0] r_z;
    logic                     r_low;
    logic                     r_ovalid;
    logic                     in_acc;

    assign o_in_stall = (r_st != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Point offsets, doubled so the ROI centre sits on an exact grid edge
    logic signed [OXW-1:0] ox;
    logic signed [OXW-1:0] oy;
    logic signed [OXW-1:0] spanx;
    logic signed [OXW-1:0] spany;
    logic                  pt_keep;
    logic                  rd_in_grid;

    always_comb begin
        spanx = OXW'(GRID_X) * $signed({{(OXW-CsW){1'b0}}, r_cs});
        spany = OXW'(GRID_Y) * $signed({{(OXW-CsW){1'b0}}, r_cs});
        ox = ((OXW'(i_point_x) - OXW'(r_rcx)) <<< 1) + spanx;
        oy = (OXW'(i_point_y) <<< 1) + spany;
        pt_keep = i_point_finite && (i_point_z >= r_zmin) && (i_point_z <= r_zmax)
                  && (r_cs != '0)
                  && (ox >= 0) && (ox < (spanx <<< 1))
                  && (oy >= 0) && (oy < (spany <<< 1));
        rd_in_grid = (int'(i_read_row) < GRID_X) && (int'(i_read_col) < GRID_Y);
    end

    // Row and column by bit-serial division
    logic            div_start;
    logic            div_done;
    logic [QB-1:0]   quo_x;
    logic [QB-1:0]   quo_y;

    assign div_start = in_acc && (i_op == OP_POINT) && pt_keep;

    pchg_div #(
        .DW (OXW),
        .QB (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_a (ox),
        .i_num_b (oy),
        .i_den   ({r_cs, 1'b0}),
        .o_done  (div_done),
        .o_quo_a (quo_x),
        .o_quo_b (quo_y)
    );

    // Cell memory, one read and one write port
    t_cell   mem [NC];
    t_cell   r_rd;
    t_cell   wr_data;
    logic    wr_en;
    t_cell   upd;

    always_comb begin
        upd = r_rd;
        if (!r_rd.used) begin
            upd.used  = 1'b1;
            upd.count = CntW'(1);
            upd.hmax  = r_z;
            upd.hmin  = r_z;
        end else begin
            if (r_rd.count != {CntW{1'b1}}) begin
                upd.count = r_rd.count + 1'b1;
            end
            if (r_z > r_rd.hmax) begin
                upd.hmax = r_z;
            end
            if (r_z < r_rd.hmin) begin
                upd.hmin = r_z;
            end
        end
        if (r_low) begin
            if (!r_rd.low_used || (r_z > r_rd.low_max)) begin
                upd.low_max = r_z;
            end
            upd.low_used = 1'b1;
        end
        wr_en   = (r_st == ST_CLR) || (r_st == ST_UPD);
        wr_data = (r_st == ST_CLR) ? '0 : upd;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (r_st == ST_RDP) begin
            r_rd <= mem[r_addr];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLR;
            r_addr   <= '0;
            r_isread <= 1'b0;
            r_rzero  <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (i_op)
                            OP_CLEAR: begin
                                r_addr <= '0;
                                r_st   <= ST_CLR;
                            end
                            OP_POINT: begin
                                r_isread <= 1'b0;
                                if (pt_keep) begin
                                    r_st <= ST_DIV;
                                end
                            end
                            OP_READ: begin
                                r_isread <= 1'b1;
                                r_rzero  <= !rd_in_grid;
                                r_addr   <= AW'(i_read_row) * AW'(GRID_Y) + AW'(i_read_col);
                                r_st     <= ST_RDP;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(NC - 1)) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_addr <= AW'(quo_x[XW-1:0]) * AW'(GRID_Y) + AW'(quo_y[YW-1:0]);
                        r_st   <= ST_RDP;
                    end
                end
                ST_RDP: begin
                    r_st <= r_isread ? ST_RESP : ST_UPD;
                end
                ST_UPD: begin
                    r_st <= ST_IDLE;
                end
                ST_RESP: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Hold point height and split flag for the write back
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_z   <= i_point_z;
            r_low <= (i_point_z <= r_split);
        end
    end

    // Result register
    logic load_out;
    assign load_out = (r_st == ST_RESP) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_cell_occupied <= !r_rzero && r_rd.used;
            o_hit_count     <= (!r_rzero && r_rd.used) ? r_rd.count : '0;
            o_z_top         <= (!r_rzero && r_rd.used) ? r_rd.hmax : '0;
            o_z_bottom      <= (!r_rzero && r_rd.used) ? r_rd.hmin : '0;
            o_low_occupied  <= !r_rzero && r_rd.low_used;
            o_low_z_top     <= (!r_rzero && r_rd.low_used) ? r_rd.low_max : '0;
        end
    end

    assign o_out_valid = r_ovalid;

    // Checks
    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == OP_CLEAR)) |=> (r_st == ST_CLR))
        else $error("clear word did not start the sweep");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out) |-> ($past(r_st) == ST_RDP || $past(r_st) == ST_RESP))
        else $error("result loaded without a cell read");

    a_empty_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_cell_occupied) |->
        (o_hit_count == '0 && o_z_top == '0 && o_z_bottom == '0))
        else $error("empty cell reports nonzero fields");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RESP) |-> !wr_en)
        else $error("cell memory written during a read");

endmodule

`default_nettype wire
